[rtl/core/assert_macros.svh]
// Assertion macros used by vem_seq in the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[rtl/core/vem_pkg.sv]
package vem_pkg;

  localparam int COORD_W    = 6;
  localparam int CNT_W      = 19;
  localparam int ABS_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 6;

  localparam logic [1:0] REC_ABSENT   = 2'd0;
  localparam logic [1:0] REC_UNKNOWN  = 2'd1;
  localparam logic [1:0] REC_FREE     = 2'd2;
  localparam logic [1:0] REC_OCCUPIED = 2'd3;

  localparam logic [1:0] ST_UNKNOWN  = 2'd0;
  localparam logic [1:0] ST_FREE     = 2'd1;
  localparam logic [1:0] ST_OCCUPIED = 2'd2;
  localparam logic [1:0] ST_OUT      = 2'd3;

  localparam logic [1:0] MAP_FREE     = 2'd1;
  localparam logic [1:0] MAP_OCCUPIED = 2'd2;
  localparam logic [1:0] MAP_OUT      = 2'd3;

  localparam logic [1:0] MODE_OBSERVE  = 2'd0;
  localparam logic [1:0] MODE_QUERY    = 2'd1;
  localparam logic [1:0] MODE_FRONTIER = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_X_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_HIGH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_Z_LOW  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_Z_HIGH = 3'd6;

  localparam int NBR_COUNT = 26;
  localparam int NBR_IDX_W = 5;
  localparam logic [NBR_IDX_W-1:0] NBR_LAST = 5'd25;

  typedef logic [5:0] nbr_off_t;

  // Each entry is {dx, dy, dz}, two-bit two's complement, z running fastest.
  localparam nbr_off_t NBR_OFF [NBR_COUNT] = '{
    6'b111111, 6'b111100, 6'b111101, 6'b110011, 6'b110000, 6'b110001,
    6'b110111, 6'b110100, 6'b110101, 6'b001111, 6'b001100, 6'b001101,
    6'b000011, 6'b000001, 6'b000111, 6'b000100, 6'b000101, 6'b011111,
    6'b011100, 6'b011101, 6'b010011, 6'b010000, 6'b010001, 6'b010111,
    6'b010100, 6'b010101
  };

  typedef struct packed {
    logic               enable;
    logic [COORD_W-1:0] x_low;
    logic [COORD_W-1:0] x_high;
    logic [COORD_W-1:0] y_low;
    logic [COORD_W-1:0] y_high;
    logic [COORD_W-1:0] z_low;
    logic [COORD_W-1:0] z_high;
  } cfg_t;

  typedef struct packed {
    logic free_inc;
    logic free_dec;
    logic occ_inc;
    logic occ_dec;
    logic unk_inc;
    logic unk_dec;
    logic absent_inc;
  } cnt_cmd_t;

  function automatic logic [1:0] merge_reading(input logic [1:0] m, input logic [1:0] inf);
    logic [1:0] res;
    if (m == MAP_OUT || inf == MAP_OUT) begin
      res = ST_OUT;
    end else if (m == MAP_OCCUPIED || inf == MAP_OCCUPIED) begin
      res = ST_OCCUPIED;
    end else if (m == MAP_FREE) begin
      res = ST_FREE;
    end else begin
      res = ST_UNKNOWN;
    end
    return res;
  endfunction

endpackage

[rtl/core/vem_store.sv]
module vem_store #(
  parameter int ADDR_W = 18
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [1:0]        wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [1:0]        rdata
);
  logic [1:0] voxel_mem [2**ADDR_W];
  logic [1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      voxel_mem[waddr] <= wdata;
    end
    rdata_r <= voxel_mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/vem_counters.sv]
module vem_counters (
  input  logic                     clk,
  input  logic                     rst_n,
  input  vem_pkg::cnt_cmd_t        cmd,
  output logic [vem_pkg::CNT_W-1:0] free_total,
  output logic [vem_pkg::CNT_W-1:0] occupied_total,
  output logic [vem_pkg::CNT_W-1:0] unknown_total,
  output logic [vem_pkg::ABS_W-1:0] absent_total
);
  import vem_pkg::*;

  logic [CNT_W-1:0] free_r, free_nxt;
  logic [CNT_W-1:0] occ_r, occ_nxt;
  logic [CNT_W-1:0] unk_r, unk_nxt;
  logic [ABS_W-1:0] abs_r, abs_nxt;

  function automatic logic [CNT_W-1:0] step19(input logic [CNT_W-1:0] c,
                                               input logic inc, input logic dec);
    logic [CNT_W-1:0] res;
    res = c;
    if (inc && !(&c)) begin
      res = c + 1'b1;
    end else if (dec && (c != '0)) begin
      res = c - 1'b1;
    end
    return res;
  endfunction

  always_comb begin
    free_nxt = step19(free_r, cmd.free_inc, cmd.free_dec);
    occ_nxt  = step19(occ_r, cmd.occ_inc, cmd.occ_dec);
    unk_nxt  = step19(unk_r, cmd.unk_inc, cmd.unk_dec);
    abs_nxt  = abs_r;
    if (cmd.absent_inc && !(&abs_r)) begin
      abs_nxt = abs_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r <= '0;
      occ_r  <= '0;
      unk_r  <= '0;
      abs_r  <= '0;
    end else begin
      free_r <= free_nxt;
      occ_r  <= occ_nxt;
      unk_r  <= unk_nxt;
      abs_r  <= abs_nxt;
    end
  end

  assign free_total     = free_r;
  assign occupied_total = occ_r;
  assign unknown_total  = unk_r;
  assign absent_total   = abs_r;

endmodule

[rtl/core/vem_seq.sv]
`include "assert_macros.svh"

module vem_seq #(
  parameter int GRID_X_CELLS = 64,
  parameter int GRID_Y_CELLS = 64,
  parameter int GRID_Z_CELLS = 64,
  localparam int XW = $clog2(GRID_X_CELLS),
  localparam int YW = $clog2(GRID_Y_CELLS),
  localparam int ZW = $clog2(GRID_Z_CELLS),
  localparam int AW = XW + YW + ZW
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_mode,
  input  logic [vem_pkg::COORD_W-1:0] in_x_index,
  input  logic [vem_pkg::COORD_W-1:0] in_y_index,
  input  logic [vem_pkg::COORD_W-1:0] in_z_index,
  input  logic [1:0]                  in_map_type,
  input  logic [1:0]                  in_inflated_type,
  input  vem_pkg::cfg_t               cfg,
  output logic                        mem_we,
  output logic [AW-1:0]               mem_waddr,
  output logic [1:0]                  mem_wdata,
  output logic [AW-1:0]               mem_raddr,
  input  logic [1:0]                  mem_rdata,
  output vem_pkg::cnt_cmd_t           cnt_cmd,
  output logic                        out_valid,
  output logic [1:0]                  out_cell_state,
  output logic                        out_observation_taken,
  output logic                        out_neighbour_unknown,
  output logic                        out_is_frontier
);
  import vem_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_CENTER = 3'd2;
  localparam logic [2:0] S_WALK   = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]           state_r, state_nxt;
  logic [AW-1:0]        clr_addr_r, clr_addr_nxt;
  logic [1:0]           mode_r, mode_nxt;
  logic [COORD_W-1:0]   x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic [1:0]           obs_r, obs_nxt;
  logic                 inb_r, inb_nxt;
  logic                 grid_r, grid_nxt;
  logic [NBR_IDX_W-1:0] k_r, k_nxt;
  logic                 nb_inb_r, nb_inb_nxt;
  logic                 ctr_free_r, ctr_free_nxt;
  logic [1:0]           res_state_r, res_state_nxt;
  logic                 res_taken_r, res_taken_nxt;
  logic                 res_nbr_r, res_nbr_nxt;
  logic                 res_front_r, res_front_nxt;

  logic                 accept;
  logic [7:0]           cx_in, cy_in, cz_in;
  logic [NBR_IDX_W-1:0] nk;
  nbr_off_t             off;
  logic [7:0]           nx, ny, nz;
  logic                 nb_ok;
  logic                 taken;
  logic [1:0]           new_rec;

  function automatic logic axis_grid(input logic [7:0] c, input int cells);
    return !c[7] && ({24'd0, c} < 32'(cells));
  endfunction

  function automatic logic axis_box(input logic [7:0] c, input int cells,
                                    input logic [COORD_W-1:0] lo,
                                    input logic [COORD_W-1:0] hi);
    return axis_grid(c, cells) && (c[6:0] >= {1'b0, lo}) && (c[6:0] <= {1'b0, hi});
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic [7:0] ax, input logic [7:0] ay,
                                               input logic [7:0] az);
    return {XW'(ax[6:0]), YW'(ay[6:0]), ZW'(az[6:0])};
  endfunction

  function automatic logic [1:0] state_of(input logic inb, input logic [1:0] rec);
    logic [1:0] res;
    if (!inb) begin
      res = ST_OUT;
    end else if (rec == REC_ABSENT) begin
      res = ST_UNKNOWN;
    end else begin
      res = rec - 2'd1;
    end
    return res;
  endfunction

  assign busy   = !(state_r == S_IDLE || state_r == S_DONE);
  assign accept = start && !busy;

  assign cx_in = {2'b00, in_x_index};
  assign cy_in = {2'b00, in_y_index};
  assign cz_in = {2'b00, in_z_index};

  assign nk  = (state_r == S_CENTER) ? '0 : ((k_r == NBR_LAST) ? k_r : k_r + 5'd1);
  assign off = NBR_OFF[nk];
  assign nx  = {2'b00, x_r} + {{6{off[5]}}, off[5:4]};
  assign ny  = {2'b00, y_r} + {{6{off[3]}}, off[3:2]};
  assign nz  = {2'b00, z_r} + {{6{off[1]}}, off[1:0]};

  assign nb_ok = axis_box(nx, GRID_X_CELLS, cfg.x_low, cfg.x_high) &&
                 axis_box(ny, GRID_Y_CELLS, cfg.y_low, cfg.y_high) &&
                 axis_box(nz, GRID_Z_CELLS, cfg.z_low, cfg.z_high);

  assign mem_raddr = (state_r == S_CENTER || state_r == S_WALK) ? cell_addr(nx, ny, nz)
                                                                : cell_addr(cx_in, cy_in, cz_in);

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    mode_nxt      = mode_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    z_nxt         = z_r;
    obs_nxt       = obs_r;
    inb_nxt       = inb_r;
    grid_nxt      = grid_r;
    k_nxt         = k_r;
    nb_inb_nxt    = nb_inb_r;
    ctr_free_nxt  = ctr_free_r;
    res_state_nxt = res_state_r;
    res_taken_nxt = res_taken_r;
    res_nbr_nxt   = res_nbr_r;
    res_front_nxt = res_front_r;
    mem_we        = 1'b0;
    mem_waddr     = cell_addr({2'b00, x_r}, {2'b00, y_r}, {2'b00, z_r});
    mem_wdata     = REC_ABSENT;
    cnt_cmd       = '0;
    taken         = 1'b0;
    new_rec       = mem_rdata;

    case (state_r)
      S_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (&clr_addr_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE, S_DONE: begin
        if (accept) begin
          mode_nxt  = in_mode;
          x_nxt     = in_x_index;
          y_nxt     = in_y_index;
          z_nxt     = in_z_index;
          obs_nxt   = merge_reading(in_map_type, in_inflated_type);
          inb_nxt   = axis_box(cx_in, GRID_X_CELLS, cfg.x_low, cfg.x_high) &&
                      axis_box(cy_in, GRID_Y_CELLS, cfg.y_low, cfg.y_high) &&
                      axis_box(cz_in, GRID_Z_CELLS, cfg.z_low, cfg.z_high);
          grid_nxt  = axis_grid(cx_in, GRID_X_CELLS) && axis_grid(cy_in, GRID_Y_CELLS) &&
                      axis_grid(cz_in, GRID_Z_CELLS);
          state_nxt = S_CENTER;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_CENTER: begin
        res_taken_nxt = 1'b0;
        res_nbr_nxt   = 1'b0;
        res_front_nxt = 1'b0;
        state_nxt     = S_DONE;
        case (mode_r)
          MODE_OBSERVE: begin
            taken = cfg.enable && inb_r && (obs_r != ST_OUT);
            if (taken) begin
              if (obs_r == ST_UNKNOWN) begin
                if (mem_rdata == REC_ABSENT) begin
                  new_rec         = REC_UNKNOWN;
                  cnt_cmd.unk_inc = 1'b1;
                end
              end else begin
                new_rec = obs_r + 2'd1;
                if (mem_rdata != new_rec) begin
                  case (mem_rdata)
                    REC_FREE:     cnt_cmd.free_dec = 1'b1;
                    REC_OCCUPIED: cnt_cmd.occ_dec  = 1'b1;
                    REC_UNKNOWN:  cnt_cmd.unk_dec  = 1'b1;
                    default: ;
                  endcase
                  if (new_rec == REC_FREE) begin
                    cnt_cmd.free_inc = 1'b1;
                  end else begin
                    cnt_cmd.occ_inc = 1'b1;
                  end
                end
              end
            end
            mem_we        = taken && (new_rec != mem_rdata);
            mem_wdata     = new_rec;
            res_state_nxt = state_of(inb_r, new_rec);
            res_taken_nxt = taken;
          end
          MODE_QUERY: begin
            res_state_nxt      = state_of(inb_r, mem_rdata);
            cnt_cmd.absent_inc = inb_r && (mem_rdata == REC_ABSENT);
          end
          MODE_FRONTIER: begin
            res_state_nxt = state_of(inb_r, mem_rdata);
            ctr_free_nxt  = grid_r && (mem_rdata == REC_FREE);
            k_nxt         = '0;
            nb_inb_nxt    = nb_ok;
            state_nxt     = S_WALK;
          end
          default: begin
            res_state_nxt = ST_UNKNOWN;
          end
        endcase
      end
      S_WALK: begin
        cnt_cmd.absent_inc = nb_inb_r && (mem_rdata == REC_ABSENT);
        if (nb_inb_r && (mem_rdata == REC_ABSENT || mem_rdata == REC_UNKNOWN)) begin
          res_nbr_nxt   = 1'b1;
          res_front_nxt = ctr_free_r;
          state_nxt     = S_DONE;
        end else if (k_r == NBR_LAST) begin
          state_nxt = S_DONE;
        end else begin
          k_nxt      = nk;
          nb_inb_nxt = nb_ok;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    z_r         <= z_nxt;
    obs_r       <= obs_nxt;
    inb_r       <= inb_nxt;
    grid_r      <= grid_nxt;
    k_r         <= k_nxt;
    nb_inb_r    <= nb_inb_nxt;
    ctr_free_r  <= ctr_free_nxt;
    res_state_r <= res_state_nxt;
    res_taken_r <= res_taken_nxt;
    res_nbr_r   <= res_nbr_nxt;
    res_front_r <= res_front_nxt;
  end

  assign out_valid             = (state_r == S_DONE);
  assign out_cell_state        = res_state_r;
  assign out_observation_taken = res_taken_r;
  assign out_neighbour_unknown = res_nbr_r;
  assign out_is_frontier       = res_front_r;

  `ASSERT_IMPLY(a_write_phase, clk, rst_n, mem_we, (state_r == S_CLEAR) || (state_r == S_CENTER))
  `ASSERT_NEXT(a_accept_center, clk, rst_n, start && !busy, state_r == S_CENTER)
  `ASSERT_IMPLY(a_walk_range, clk, rst_n, state_r == S_WALK, k_r <= NBR_LAST)
  `ASSERT_IMPLY(a_front_has_nbr, clk, rst_n, out_valid && out_is_frontier, out_neighbour_unknown)
  `ASSERT_IMPLY(a_taken_in_box, clk, rst_n, out_valid && out_observation_taken, out_cell_state != ST_OUT)

endmodule

[rtl/core/voxel_exploration_memory_core.sv]
// Sequence: observe, query and the unused mode go from S_CENTER to S_DONE, where out_valid
// is high; a frontier test goes from S_CENTER through S_WALK, reading up to 26 neighbors.
// Transactions: a new start is taken in the cycle out_valid is high, and only in S_IDLE or
// S_DONE, so a new one is not taken before the last one is done; the voxel memory's single
// read port reads one entry per cycle. The receiver cannot stall.
// Reset: the memory is cleared one entry per cycle, busy stays high.
module voxel_exploration_memory_core #(
  parameter int GRID_X_CELLS = 64,
  parameter int GRID_Y_CELLS = 64,
  parameter int GRID_Z_CELLS = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_mode,
  input  logic [vem_pkg::COORD_W-1:0]    in_x_index,
  input  logic [vem_pkg::COORD_W-1:0]    in_y_index,
  input  logic [vem_pkg::COORD_W-1:0]    in_z_index,
  input  logic [1:0]                     in_map_type,
  input  logic [1:0]                     in_inflated_type,
  input  logic                           cfg_we,
  input  logic [vem_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vem_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           out_valid,
  output logic [1:0]                     out_cell_state,
  output logic                           out_observation_taken,
  output logic                           out_neighbour_unknown,
  output logic                           out_is_frontier,
  output logic [vem_pkg::CNT_W-1:0]      out_free_total,
  output logic [vem_pkg::CNT_W-1:0]      out_occupied_total,
  output logic [vem_pkg::CNT_W-1:0]      out_explicit_unknown_total,
  output logic [vem_pkg::ABS_W-1:0]      out_absent_read_total
);
  import vem_pkg::*;

  localparam int AW = $clog2(GRID_X_CELLS) + $clog2(GRID_Y_CELLS) + $clog2(GRID_Z_CELLS);

  cfg_t          cfg_r, cfg_nxt;
  cnt_cmd_t      cnt_cmd;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [1:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [1:0]    mem_rdata;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_ENABLE: cfg_nxt.enable = cfg_data[0];
        CFG_X_LOW:  cfg_nxt.x_low  = cfg_data;
        CFG_X_HIGH: cfg_nxt.x_high = cfg_data;
        CFG_Y_LOW:  cfg_nxt.y_low  = cfg_data;
        CFG_Y_HIGH: cfg_nxt.y_high = cfg_data;
        CFG_Z_LOW:  cfg_nxt.z_low  = cfg_data;
        CFG_Z_HIGH: cfg_nxt.z_high = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable <= 1'b1;
      cfg_r.x_low  <= '0;
      cfg_r.x_high <= '1;
      cfg_r.y_low  <= '0;
      cfg_r.y_high <= '1;
      cfg_r.z_low  <= '0;
      cfg_r.z_high <= '1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  vem_seq #(
    .GRID_X_CELLS(GRID_X_CELLS),
    .GRID_Y_CELLS(GRID_Y_CELLS),
    .GRID_Z_CELLS(GRID_Z_CELLS)
  ) u_seq (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_mode              (in_mode),
    .in_x_index           (in_x_index),
    .in_y_index           (in_y_index),
    .in_z_index           (in_z_index),
    .in_map_type          (in_map_type),
    .in_inflated_type     (in_inflated_type),
    .cfg                  (cfg_r),
    .mem_we               (mem_we),
    .mem_waddr            (mem_waddr),
    .mem_wdata            (mem_wdata),
    .mem_raddr            (mem_raddr),
    .mem_rdata            (mem_rdata),
    .cnt_cmd              (cnt_cmd),
    .out_valid            (out_valid),
    .out_cell_state       (out_cell_state),
    .out_observation_taken(out_observation_taken),
    .out_neighbour_unknown(out_neighbour_unknown),
    .out_is_frontier      (out_is_frontier)
  );

  vem_store #(
    .ADDR_W(AW)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  vem_counters u_counters (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cnt_cmd),
    .free_total    (out_free_total),
    .occupied_total(out_occupied_total),
    .unknown_total (out_explicit_unknown_total),
    .absent_total  (out_absent_read_total)
  );

endmodule

[tb/voxel_exploration_memory_core_test.sv]
module voxel_exploration_memory_core_test;
  import vem_pkg::*;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam logic [1:0] MAP_UNKNOWN = 2'd0;
  localparam int GRID = 64;
  localparam int CELLS = GRID * GRID * GRID;

  typedef struct packed {
    logic [1:0] mode;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [1:0] map_type;
    logic [1:0] inflated_type;
  } voxel_op_t;

  typedef struct packed {
    logic [1:0] state;
    logic taken;
    logic nbr_unknown;
    logic frontier;
    logic [CNT_W-1:0] free_total;
    logic [CNT_W-1:0] occupied_total;
    logic [CNT_W-1:0] unknown_total;
    logic [ABS_W-1:0] absent_total;
  } voxel_result_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [1:0] in_mode;
  logic [COORD_W-1:0] in_x_index;
  logic [COORD_W-1:0] in_y_index;
  logic [COORD_W-1:0] in_z_index;
  logic [1:0] in_map_type;
  logic [1:0] in_inflated_type;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic out_valid;
  logic [1:0] out_cell_state;
  logic out_observation_taken;
  logic out_neighbour_unknown;
  logic out_is_frontier;
  logic [CNT_W-1:0] out_free_total;
  logic [CNT_W-1:0] out_occupied_total;
  logic [CNT_W-1:0] out_explicit_unknown_total;
  logic [ABS_W-1:0] out_absent_read_total;

  logic [1:0] vox_rec [0:CELLS-1];
  logic [CNT_W-1:0] free_cnt;
  logic [CNT_W-1:0] occ_cnt;
  logic [CNT_W-1:0] unk_cnt;
  logic [ABS_W-1:0] absent_cnt;
  logic box_en;
  logic [COORD_W-1:0] box_lo [3];
  logic [COORD_W-1:0] box_hi [3];

  voxel_result_t pending_voxel_results [$];
  int mismatch_count = 0;
  bit steady = 0;

  voxel_exploration_memory_core uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_mode(in_mode),
    .in_x_index(in_x_index),
    .in_y_index(in_y_index),
    .in_z_index(in_z_index),
    .in_map_type(in_map_type),
    .in_inflated_type(in_inflated_type),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .out_valid(out_valid),
    .out_cell_state(out_cell_state),
    .out_observation_taken(out_observation_taken),
    .out_neighbour_unknown(out_neighbour_unknown),
    .out_is_frontier(out_is_frontier),
    .out_free_total(out_free_total),
    .out_occupied_total(out_occupied_total),
    .out_explicit_unknown_total(out_explicit_unknown_total),
    .out_absent_read_total(out_absent_read_total)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic void clear_voxel_map();
    for (int i = 0; i < CELLS; i++) begin
      vox_rec[i] = REC_ABSENT;
    end
    free_cnt = '0;
    occ_cnt = '0;
    unk_cnt = '0;
    absent_cnt = '0;
    box_en = 1'b1;
    for (int a = 0; a < 3; a++) begin
      box_lo[a] = '0;
      box_hi[a] = '1;
    end
  endfunction

  function automatic int cell_addr(input int x, input int y, input int z);
    return (x * GRID + y) * GRID + z;
  endfunction

  function automatic bit in_box(input int x, input int y, input int z);
    if (x < 0 || y < 0 || z < 0 || x >= GRID || y >= GRID || z >= GRID) begin
      return 1'b0;
    end
    return x >= box_lo[0] && x <= box_hi[0] && y >= box_lo[1] && y <= box_hi[1] &&
           z >= box_lo[2] && z <= box_hi[2];
  endfunction

  function automatic logic [1:0] cell_state_at(input int x, input int y, input int z,
                                               input bit count_absent);
    logic [1:0] rec;
    if (!in_box(x, y, z)) begin
      return ST_OUT;
    end
    rec = vox_rec[cell_addr(x, y, z)];
    if (rec == REC_ABSENT) begin
      if (count_absent && absent_cnt != '1) begin
        absent_cnt++;
      end
      return ST_UNKNOWN;
    end
    return rec - 2'd1;
  endfunction

  function automatic void step_count(inout logic [CNT_W-1:0] c, input bit up);
    if (up) begin
      if (c != '1) c++;
    end else if (c != '0) begin
      c--;
    end
  endfunction

  function automatic logic [1:0] fold_readings(input logic [1:0] m, input logic [1:0] inf);
    if (m == MAP_OUT || inf == MAP_OUT) return ST_OUT;
    if (m == MAP_OCCUPIED || inf == MAP_OCCUPIED) return ST_OCCUPIED;
    if (m == MAP_FREE) return ST_FREE;
    return ST_UNKNOWN;
  endfunction

  function automatic bit apply_reading(input int x, input int y, input int z,
                                       input logic [1:0] m, input logic [1:0] inf);
    logic [1:0] seen;
    logic [1:0] old;
    logic [1:0] fresh;
    int a;
    if (!box_en || !in_box(x, y, z)) return 1'b0;
    seen = fold_readings(m, inf);
    if (seen == ST_OUT) return 1'b0;
    a = cell_addr(x, y, z);
    old = vox_rec[a];
    if (seen == ST_UNKNOWN) begin
      if (old == REC_ABSENT) begin
        vox_rec[a] = REC_UNKNOWN;
        step_count(unk_cnt, 1'b1);
      end
      return 1'b1;
    end
    fresh = seen + 2'd1;
    if (old != fresh) begin
      case (old)
        REC_FREE: step_count(free_cnt, 1'b0);
        REC_OCCUPIED: step_count(occ_cnt, 1'b0);
        REC_UNKNOWN: step_count(unk_cnt, 1'b0);
        default: ;
      endcase
      if (fresh == REC_FREE) step_count(free_cnt, 1'b1);
      else step_count(occ_cnt, 1'b1);
      vox_rec[a] = fresh;
    end
    return 1'b1;
  endfunction

  function automatic voxel_result_t voxel_outcome(input voxel_op_t op);
    voxel_result_t r;
    int x;
    int y;
    int z;
    r = '0;
    x = int'(op.x);
    y = int'(op.y);
    z = int'(op.z);
    case (op.mode)
      MODE_OBSERVE: begin
        r.taken = apply_reading(x, y, z, op.map_type, op.inflated_type);
        r.state = cell_state_at(x, y, z, 1'b0);
      end
      MODE_QUERY: begin
        r.state = cell_state_at(x, y, z, 1'b1);
      end
      MODE_FRONTIER: begin
        r.state = cell_state_at(x, y, z, 1'b0);
        for (int dx = -1; dx <= 1; dx++) begin
          for (int dy = -1; dy <= 1; dy++) begin
            for (int dz = -1; dz <= 1; dz++) begin
              if (!r.nbr_unknown && (dx != 0 || dy != 0 || dz != 0)) begin
                if (cell_state_at(x + dx, y + dy, z + dz, 1'b1) == ST_UNKNOWN) begin
                  r.nbr_unknown = 1'b1;
                end
              end
            end
          end
        end
        r.frontier = r.nbr_unknown && vox_rec[cell_addr(x, y, z)] == REC_FREE;
      end
      default: ;
    endcase
    r.free_total = free_cnt;
    r.occupied_total = occ_cnt;
    r.unknown_total = unk_cnt;
    r.absent_total = absent_cnt;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    voxel_result_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_voxel_results.size() == 0) begin
        $display("%0t result without transaction: expected none actual state %0d",
                 $time, out_cell_state);
        mismatch_count++;
      end else begin
        want = pending_voxel_results.pop_front();
        check_field("cell_state", 32'(want.state), 32'(out_cell_state));
        check_field("observation_taken", 32'(want.taken), 32'(out_observation_taken));
        check_field("neighbour_unknown", 32'(want.nbr_unknown), 32'(out_neighbour_unknown));
        check_field("is_frontier", 32'(want.frontier), 32'(out_is_frontier));
        check_field("free_total", 32'(want.free_total), 32'(out_free_total));
        check_field("occupied_total", 32'(want.occupied_total), 32'(out_occupied_total));
        check_field("explicit_unknown_total", 32'(want.unknown_total),
                    32'(out_explicit_unknown_total));
        check_field("absent_read_total", want.absent_total, out_absent_read_total);
      end
    end
  end

  function automatic voxel_op_t op_at(input logic [1:0] mode, input int x, input int y,
                                      input int z, input logic [3:0] reading);
    voxel_op_t op;
    op.mode = mode;
    op.x = x[COORD_W-1:0];
    op.y = y[COORD_W-1:0];
    op.z = z[COORD_W-1:0];
    op.map_type = reading[3:2];
    op.inflated_type = reading[1:0];
    return op;
  endfunction

  function automatic logic [3:0] pick_reading(input bit mostly_solid);
    int r;
    logic [1:0] v;
    r = $urandom_range(0, mostly_solid ? 79 : 99);
    v = 2'($urandom_range(0, 2));
    if (r < 40) return {MAP_FREE, v[0] ? MAP_FREE : MAP_UNKNOWN};
    if (r < 55) return {MAP_OCCUPIED, v};
    if (r < 70) return {v, MAP_OCCUPIED};
    if (r < 85) return {MAP_UNKNOWN, v[0] ? MAP_FREE : MAP_UNKNOWN};
    return 4'($urandom_range(0, 15));
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Entered and left at a falling edge; start stays high when no gap follows.
  task automatic issue_voxel_op(input voxel_op_t op);
    int gap;
    in_mode <= op.mode;
    in_x_index <= op.x;
    in_y_index <= op.y;
    in_z_index <= op.z;
    in_map_type <= op.map_type;
    in_inflated_type <= op.inflated_type;
    start <= 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    pending_voxel_results = {pending_voxel_results, voxel_outcome(op)};
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    while (pending_voxel_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_DATA_W-1:0];
    @(negedge clk);
  endtask

  task automatic program_box(input logic en, input int xl, input int xh, input int yl,
                             input int yh, input int zl, input int zh);
    settle();
    put_reg(CFG_ENABLE, int'(en));
    put_reg(CFG_X_LOW, xl);
    put_reg(CFG_X_HIGH, xh);
    put_reg(CFG_Y_LOW, yl);
    put_reg(CFG_Y_HIGH, yh);
    put_reg(CFG_Z_LOW, zl);
    put_reg(CFG_Z_HIGH, zh);
    cfg_we <= 1'b0;
    box_en = en;
    box_lo[0] = xl[COORD_W-1:0];
    box_hi[0] = xh[COORD_W-1:0];
    box_lo[1] = yl[COORD_W-1:0];
    box_hi[1] = yh[COORD_W-1:0];
    box_lo[2] = zl[COORD_W-1:0];
    box_hi[2] = zh[COORD_W-1:0];
  endtask

  task automatic test_directed();
    program_box(1'b1, 0, 63, 0, 63, 0, 63);
    issue_voxel_op(op_at(MODE_QUERY, 0, 0, 0, 4'h0));
    issue_voxel_op(op_at(MODE_QUERY, 63, 63, 63, 4'hF));
    issue_voxel_op(op_at(MODE_FRONTIER, 0, 0, 0, 4'h0));
    issue_voxel_op(op_at(MODE_OBSERVE, 5, 5, 5, {MAP_UNKNOWN, MAP_UNKNOWN}));
    issue_voxel_op(op_at(MODE_OBSERVE, 5, 5, 5, {MAP_FREE, MAP_UNKNOWN}));
    issue_voxel_op(op_at(MODE_OBSERVE, 5, 5, 5, {MAP_UNKNOWN, MAP_UNKNOWN}));
    issue_voxel_op(op_at(MODE_OBSERVE, 5, 5, 5, {MAP_FREE, MAP_FREE}));
    issue_voxel_op(op_at(MODE_FRONTIER, 5, 5, 5, 4'h0));
    issue_voxel_op(op_at(MODE_OBSERVE, 5, 5, 5, {MAP_UNKNOWN, MAP_OCCUPIED}));
    issue_voxel_op(op_at(MODE_OBSERVE, 5, 5, 5, {MAP_OCCUPIED, MAP_FREE}));
    issue_voxel_op(op_at(MODE_OBSERVE, 5, 5, 6, {MAP_UNKNOWN, MAP_FREE}));
    issue_voxel_op(op_at(MODE_OBSERVE, 5, 5, 7, {MAP_OUT, MAP_UNKNOWN}));
    issue_voxel_op(op_at(MODE_OBSERVE, 5, 5, 7, {MAP_FREE, MAP_OUT}));
    issue_voxel_op(op_at(MODE_OBSERVE, 63, 0, 63, {MAP_FREE, MAP_UNKNOWN}));
    issue_voxel_op(op_at(MODE_OBSERVE, 5, 5, 5, {MAP_FREE, MAP_UNKNOWN}));
    issue_voxel_op(op_at(MODE_OBSERVE, 6, 5, 5, {MAP_FREE, MAP_FREE}));
    issue_voxel_op(op_at(MODE_SPARE, 5, 5, 5, {MAP_OUT, MAP_OUT}));
    issue_voxel_op(op_at(MODE_QUERY, 5, 5, 5, 4'h0));
    issue_voxel_op(op_at(MODE_FRONTIER, 63, 0, 63, 4'h0));
    issue_voxel_op(op_at(MODE_QUERY, 5, 5, 7, 4'h0));
    issue_voxel_op(op_at(MODE_OBSERVE, 0, 63, 0, {MAP_OCCUPIED, MAP_OCCUPIED}));
    issue_voxel_op(op_at(MODE_FRONTIER, 0, 63, 0, 4'h0));
  endtask

  task automatic test_disabled_memory();
    program_box(1'b0, 0, 0, 0, 0, 0, 0);
    issue_voxel_op(op_at(MODE_OBSERVE, 0, 0, 0, {MAP_FREE, MAP_UNKNOWN}));
    issue_voxel_op(op_at(MODE_OBSERVE, 0, 0, 0, {MAP_UNKNOWN, MAP_UNKNOWN}));
    issue_voxel_op(op_at(MODE_QUERY, 0, 0, 0, 4'h0));
    issue_voxel_op(op_at(MODE_FRONTIER, 0, 0, 0, 4'h0));
  endtask

  task automatic test_box_edges();
    // The centre lies outside a one-slice box but is stored free next to an absent voxel.
    program_box(1'b1, 5, 5, 0, 63, 0, 63);
    issue_voxel_op(op_at(MODE_FRONTIER, 6, 5, 5, 4'h0));
    issue_voxel_op(op_at(MODE_OBSERVE, 6, 5, 5, {MAP_OCCUPIED, MAP_UNKNOWN}));
    issue_voxel_op(op_at(MODE_QUERY, 4, 5, 5, 4'h0));
    issue_voxel_op(op_at(MODE_QUERY, 5, 9, 9, 4'h0));
    program_box(1'b1, 63, 0, 63, 0, 63, 0);
    issue_voxel_op(op_at(MODE_OBSERVE, 10, 10, 10, {MAP_FREE, MAP_UNKNOWN}));
    issue_voxel_op(op_at(MODE_QUERY, 0, 0, 0, 4'h0));
    issue_voxel_op(op_at(MODE_FRONTIER, 6, 5, 5, 4'h0));
    program_box(1'b1, 63, 63, 63, 63, 63, 63);
    issue_voxel_op(op_at(MODE_QUERY, 63, 63, 63, 4'h0));
    issue_voxel_op(op_at(MODE_OBSERVE, 63, 63, 63, {MAP_FREE, MAP_FREE}));
    issue_voxel_op(op_at(MODE_FRONTIER, 63, 63, 63, 4'h0));
    issue_voxel_op(op_at(MODE_OBSERVE, 62, 63, 63, {MAP_FREE, MAP_FREE}));
  endtask

  task automatic probe_near(input int lx, input int hx, input int ly, input int hy,
                            input int lz, input int hz);
    int r;
    int x;
    int y;
    int z;
    r = $urandom_range(0, 99);
    x = $urandom_range(lx > 0 ? lx - 1 : 0, hx < GRID - 1 ? hx + 1 : GRID - 1);
    y = $urandom_range(ly > 0 ? ly - 1 : 0, hy < GRID - 1 ? hy + 1 : GRID - 1);
    z = $urandom_range(lz > 0 ? lz - 1 : 0, hz < GRID - 1 ? hz + 1 : GRID - 1);
    if (r < 70) issue_voxel_op(op_at(MODE_FRONTIER, x, y, z, pick_reading(1'b0)));
    else if (r < 90) issue_voxel_op(op_at(MODE_QUERY, x, y, z, pick_reading(1'b0)));
    else issue_voxel_op(op_at(MODE_OBSERVE, x, y, z, pick_reading(1'b0)));
  endtask

  // Fills a small box in random order and probes it while it fills and afterwards.
  task automatic fill_and_probe(input int lx, input int hx, input int ly, input int hy,
                                input int lz, input int hz);
    int cells [$];
    int j;
    int tmp;
    program_box(1'b1, lx, hx, ly, hy, lz, hz);
    for (int x = lx; x <= hx; x++) begin
      for (int y = ly; y <= hy; y++) begin
        for (int z = lz; z <= hz; z++) begin
          cells = {cells, (x << 12) | (y << 6) | z};
        end
      end
    end
    for (int i = cells.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = cells[i];
      cells[i] = cells[j];
      cells[j] = tmp;
    end
    for (int i = 0; i < cells.size(); i++) begin
      if ($urandom_range(0, 3) == 0) probe_near(lx, hx, ly, hy, lz, hz);
      issue_voxel_op(op_at(MODE_OBSERVE, (cells[i] >> 12) & 63, (cells[i] >> 6) & 63,
                           cells[i] & 63, pick_reading(1'b1)));
    end
    repeat (15) probe_near(lx, hx, ly, hy, lz, hz);
  endtask

  task automatic test_filled_boxes();
    int bx;
    int by;
    int bz;
    fill_and_probe(0, 2, 0, 2, 0, 2);
    steady = 1'b1;
    fill_and_probe(61, 63, 61, 63, 61, 63);
    steady = 1'b0;
    fill_and_probe(0, 1, 62, 63, 30, 32);
    repeat (2) begin
      bx = $urandom_range(0, 61);
      by = $urandom_range(0, 61);
      bz = $urandom_range(0, 61);
      fill_and_probe(bx, bx + $urandom_range(1, 2), by, by + $urandom_range(1, 2),
                     bz, bz + $urandom_range(1, 2));
    end
  endtask

  function automatic int pick_coord(input int base);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return base + $urandom_range(0, 4);
    if (r < 85) return $urandom_range(0, GRID - 1);
    return $urandom_range(0, 1) ? GRID - 1 : 0;
  endfunction

  task automatic test_random_region();
    int base [3];
    int r;
    logic [1:0] mode;
    program_box(1'b1, 0, 63, 0, 63, 0, 63);
    for (int n = 0; n < 200; n++) begin
      if (n % 25 == 0) begin
        for (int a = 0; a < 3; a++) base[a] = $urandom_range(0, GRID - 5);
      end
      steady = n < 40;
      r = $urandom_range(0, 99);
      if (r < 45) mode = MODE_OBSERVE;
      else if (r < 65) mode = MODE_QUERY;
      else if (r < 95) mode = MODE_FRONTIER;
      else mode = MODE_SPARE;
      issue_voxel_op(op_at(mode, pick_coord(base[0]), pick_coord(base[1]),
                           pick_coord(base[2]), pick_reading(1'b0)));
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_mode = MODE_OBSERVE;
    in_x_index = '0;
    in_y_index = '0;
    in_z_index = '0;
    in_map_type = MAP_UNKNOWN;
    in_inflated_type = MAP_UNKNOWN;
    cfg_we = 1'b0;
    cfg_index = CFG_ENABLE;
    cfg_data = '0;
    clear_voxel_map();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    @(negedge clk);
    test_directed();
    test_disabled_memory();
    test_box_edges();
    test_filled_boxes();
    test_random_region();
    settle();
    repeat (30) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Timeout for the whole run, which includes the store clear after reset.
  initial begin
    #6000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
